/* rtl/core/frc_pkg.sv */
// Shared types and constants for the sphere/box frustum culling core.
// No dependencies; every other file of the core refers to this package by scoped name.
package frc_pkg;

	localparam int NUM_PLANE_REGS = 6;
	localparam int PLANE_COUNT    = 6;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 64;

	localparam int COORD_W  = 24;
	localparam int RADIUS_W = 23;
	localparam int NORM_W   = 12;
	localparam int DIST_W   = 28;
	localparam int AXIS_W   = COORD_W + 1;
	localparam int ABSN_W   = NORM_W + 1;
	localparam int PA_W     = NORM_W + AXIS_W;
	localparam int PE_W     = ABSN_W + AXIS_W;
	localparam int SUM_W    = PE_W + 4;

	localparam int D_SHIFT_SPHERE = 10;
	localparam int D_SHIFT_BOX    = 11;
	localparam int R_SHIFT        = 10;

	localparam logic OP_SPHERE = 1'b0;
	localparam logic OP_BOX    = 1'b1;

	typedef struct packed {
		logic signed [DIST_W-1:0] d;
		logic signed [NORM_W-1:0] nz;
		logic signed [NORM_W-1:0] ny;
		logic signed [NORM_W-1:0] nx;
	} plane_t;

	typedef plane_t [NUM_PLANE_REGS-1:0] plane_set_t;

	typedef struct packed {
		logic en;
		logic vin;
	} stage_ctl_t;

	typedef struct packed {
		logic                          op;
		logic [RADIUS_W-1:0]           radius;
		logic [2:0][AXIS_W-1:0]        a;
		logic [2:0][AXIS_W-1:0]        e;
	} prep_t;

	typedef struct packed {
		logic                                  op;
		logic [RADIUS_W-1:0]                   radius;
		logic [PLANE_COUNT-1:0][2:0][PA_W-1:0] pa;
		logic [PLANE_COUNT-1:0][2:0][PE_W-1:0] pe;
	} mul_t;

	typedef struct packed {
		logic [PLANE_COUNT-1:0][SUM_W-1:0] lhs;
		logic [PLANE_COUNT-1:0][SUM_W-1:0] rhs;
	} sum_t;

endpackage

/* rtl/core/frc_if.sv */
// Valid/ready channel interfaces for volume requests and visibility results.
// Depends on frc_pkg for field widths.
interface frc_req_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 op;
	logic signed [frc_pkg::COORD_W-1:0]   center_x;
	logic signed [frc_pkg::COORD_W-1:0]   center_y;
	logic signed [frc_pkg::COORD_W-1:0]   center_z;
	logic        [frc_pkg::RADIUS_W-1:0]  radius;
	logic signed [frc_pkg::COORD_W-1:0]   min_x;
	logic signed [frc_pkg::COORD_W-1:0]   min_y;
	logic signed [frc_pkg::COORD_W-1:0]   min_z;
	logic signed [frc_pkg::COORD_W-1:0]   max_x;
	logic signed [frc_pkg::COORD_W-1:0]   max_y;
	logic signed [frc_pkg::COORD_W-1:0]   max_z;

	modport source (output valid, op, center_x, center_y, center_z, radius,
		min_x, min_y, min_z, max_x, max_y, max_z, input ready);
	modport sink (input valid, op, center_x, center_y, center_z, radius,
		min_x, min_y, min_z, max_x, max_y, max_z, output ready);
endinterface

interface frc_rsp_if;
	logic valid;
	logic ready;
	logic visible;

	modport source (output valid, visible, input ready);
	modport sink (input valid, visible, output ready);
endinterface

/* rtl/core/frc_cfg_regs.sv */
// Plane register file written through the plain configuration port.
// Depends on frc_pkg for the plane packing and index width.
module frc_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [frc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [frc_pkg::CFG_DATA_W-1:0]   cfg_data,
	output frc_pkg::plane_set_t              planes
);

	frc_pkg::plane_set_t planes_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			planes_q <= '0;
		end else if (cfg_we) begin
			for (int i = 0; i < frc_pkg::NUM_PLANE_REGS; i++) begin
				if (cfg_index == frc_pkg::CFG_IDX_W'(i)) begin
					planes_q[i] <= frc_pkg::plane_t'(cfg_data);
				end
			end
		end
	end

	assign planes = planes_q;

endmodule

/* rtl/core/frc_prep.sv */
// Stage 1: register the request and form per-axis operands (center or min+max, max-min).
// Depends on frc_pkg.
module frc_prep (
	input  logic                              clk,
	input  logic                              arst_n,
	input  frc_pkg::stage_ctl_t               ctl,
	input  logic                              op,
	input  logic [2:0][frc_pkg::COORD_W-1:0]  center,
	input  logic [frc_pkg::RADIUS_W-1:0]      radius,
	input  logic [2:0][frc_pkg::COORD_W-1:0]  vmin,
	input  logic [2:0][frc_pkg::COORD_W-1:0]  vmax,
	output logic                              valid_s1,
	output frc_pkg::prep_t                    data_s1
);

	frc_pkg::prep_t nxt;

	always_comb begin
		nxt.op     = op;
		nxt.radius = radius;
		for (int k = 0; k < 3; k++) begin
			if (op == frc_pkg::OP_BOX) begin
				nxt.a[k] = frc_pkg::AXIS_W'($signed(vmin[k]))
					+ frc_pkg::AXIS_W'($signed(vmax[k]));
			end else begin
				nxt.a[k] = frc_pkg::AXIS_W'($signed(center[k]));
			end
			nxt.e[k] = frc_pkg::AXIS_W'($signed(vmax[k]))
				- frc_pkg::AXIS_W'($signed(vmin[k]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ctl.en) begin
			valid_s1 <= ctl.vin;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en && ctl.vin) begin
			data_s1 <= nxt;
		end
	end

endmodule

/* rtl/core/frc_mul.sv */
// Stage 2: per-plane products n*a and |n|*e on every axis.
// Depends on frc_pkg and the plane set from frc_cfg_regs.
module frc_mul (
	input  logic                 clk,
	input  logic                 arst_n,
	input  frc_pkg::stage_ctl_t  ctl,
	input  frc_pkg::plane_set_t  planes,
	input  frc_pkg::prep_t       data_s1,
	output logic                 valid_s2,
	output frc_pkg::mul_t        data_s2
);

	frc_pkg::mul_t nxt;
	logic signed [2:0][frc_pkg::NORM_W-1:0] n;
	logic signed [frc_pkg::ABSN_W-1:0]      absn;

	always_comb begin
		nxt.op     = data_s1.op;
		nxt.radius = data_s1.radius;
		n          = '0;
		absn       = '0;
		for (int p = 0; p < frc_pkg::PLANE_COUNT; p++) begin
			n[0] = planes[p].nx;
			n[1] = planes[p].ny;
			n[2] = planes[p].nz;
			for (int k = 0; k < 3; k++) begin
				absn = n[k][frc_pkg::NORM_W-1] ? -frc_pkg::ABSN_W'($signed(n[k]))
					: frc_pkg::ABSN_W'($signed(n[k]));
				nxt.pa[p][k] = frc_pkg::PA_W'($signed(n[k]))
					* frc_pkg::PA_W'($signed(data_s1.a[k]));
				nxt.pe[p][k] = frc_pkg::PE_W'(absn)
					* frc_pkg::PE_W'($signed(data_s1.e[k]));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ctl.en) begin
			valid_s2 <= ctl.vin;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en && ctl.vin) begin
			data_s2 <= nxt;
		end
	end

endmodule

/* rtl/core/frc_sum.sv */
// Stage 3: per-plane distance and bound sums, with the plane offset scaled by volume kind.
// Depends on frc_pkg and the plane set from frc_cfg_regs.
module frc_sum (
	input  logic                 clk,
	input  logic                 arst_n,
	input  frc_pkg::stage_ctl_t  ctl,
	input  frc_pkg::plane_set_t  planes,
	input  frc_pkg::mul_t        data_s2,
	output logic                 valid_s3,
	output frc_pkg::sum_t        data_s3
);

	frc_pkg::sum_t nxt;
	logic signed [frc_pkg::SUM_W-1:0] dterm;
	logic signed [frc_pkg::SUM_W-1:0] proj;

	always_comb begin
		dterm = '0;
		proj  = '0;
		for (int p = 0; p < frc_pkg::PLANE_COUNT; p++) begin
			if (data_s2.op == frc_pkg::OP_BOX) begin
				dterm = frc_pkg::SUM_W'(planes[p].d) <<< frc_pkg::D_SHIFT_BOX;
			end else begin
				dterm = frc_pkg::SUM_W'(planes[p].d) <<< frc_pkg::D_SHIFT_SPHERE;
			end
			nxt.lhs[p] = frc_pkg::SUM_W'($signed(data_s2.pa[p][0]))
				+ frc_pkg::SUM_W'($signed(data_s2.pa[p][1]))
				+ frc_pkg::SUM_W'($signed(data_s2.pa[p][2])) + dterm;
			proj = frc_pkg::SUM_W'($signed(data_s2.pe[p][0]))
				+ frc_pkg::SUM_W'($signed(data_s2.pe[p][1]))
				+ frc_pkg::SUM_W'($signed(data_s2.pe[p][2]));
			if (data_s2.op == frc_pkg::OP_BOX) begin
				nxt.rhs[p] = proj;
			end else begin
				nxt.rhs[p] = frc_pkg::SUM_W'(data_s2.radius) << frc_pkg::R_SHIFT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ctl.en) begin
			valid_s3 <= ctl.vin;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en && ctl.vin) begin
			data_s3 <= nxt;
		end
	end

endmodule

/* rtl/core/frc_cmp.sv */
// Stage 4: per-plane compare, merge of cull flags, and the result register.
// Depends on frc_pkg.
module frc_cmp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  frc_pkg::stage_ctl_t  ctl,
	input  frc_pkg::sum_t        data_s3,
	output logic                 valid_s4,
	output logic                 visible_s4
);

	logic [frc_pkg::PLANE_COUNT-1:0] cull;

	always_comb begin
		for (int p = 0; p < frc_pkg::PLANE_COUNT; p++) begin
			cull[p] = $signed(data_s3.lhs[p]) > $signed(data_s3.rhs[p]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (ctl.en) begin
			valid_s4 <= ctl.vin;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en && ctl.vin) begin
			visible_s4 <= ~|cull;
		end
	end

endmodule

/* rtl/core/frustum_cull_sphere_aabb_core.sv */
// Frustum culling core: sphere or box against the configured planes, four register stages.
// Request beats pass the prep, mul, sum and cmp registers; one beat per cycle while
// rsp.ready is high, the multiplier and sum stages each hold one item and never iterate.
// A stall holds occupied stages with no gap ahead of them; the rest still move into gaps.
// Reset clears all plane registers to zero and empties the pipeline.
// Depends on frc_pkg, frc_if and the frc_* stage modules.
module frustum_cull_sphere_aabb_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [frc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [frc_pkg::CFG_DATA_W-1:0]  cfg_data,
	frc_req_if.sink                         req,
	frc_rsp_if.source                       rsp
);

	frc_pkg::plane_set_t planes;
	frc_pkg::prep_t      data_s1;
	frc_pkg::mul_t       data_s2;
	frc_pkg::sum_t       data_s3;
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic visible_s4;
	logic en1, en2, en3, en4;
	frc_pkg::stage_ctl_t ctl1, ctl2, ctl3, ctl4;

	// advance a stage when it is empty or its successor advances
	assign en4 = !valid_s4 || rsp.ready;
	assign en3 = !valid_s3 || en4;
	assign en2 = !valid_s2 || en3;
	assign en1 = !valid_s1 || en2;

	assign ctl1 = '{en: en1, vin: req.valid};
	assign ctl2 = '{en: en2, vin: valid_s1};
	assign ctl3 = '{en: en3, vin: valid_s2};
	assign ctl4 = '{en: en4, vin: valid_s3};

	assign req.ready   = en1;
	assign rsp.valid   = valid_s4;
	assign rsp.visible = visible_s4;

	frc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.planes    (planes)
	);

	frc_prep u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl1),
		.op       (req.op),
		.center   ({req.center_z, req.center_y, req.center_x}),
		.radius   (req.radius),
		.vmin     ({req.min_z, req.min_y, req.min_x}),
		.vmax     ({req.max_z, req.max_y, req.max_x}),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1)
	);

	frc_mul u_mul (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl2),
		.planes   (planes),
		.data_s1  (data_s1),
		.valid_s2 (valid_s2),
		.data_s2  (data_s2)
	);

	frc_sum u_sum (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl3),
		.planes   (planes),
		.data_s2  (data_s2),
		.valid_s3 (valid_s3),
		.data_s3  (data_s3)
	);

	frc_cmp u_cmp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl4),
		.data_s3    (data_s3),
		.valid_s4   (valid_s4),
		.visible_s4 (visible_s4)
	);

endmodule
